### design/serial_command_line_parser_assert.svh
// Assertion macros for the serial command line parser.
// Both macros expect clk_i and rst_ni to be in scope.
`ifndef SERIAL_COMMAND_LINE_PARSER_ASSERT_SVH
`define SERIAL_COMMAND_LINE_PARSER_ASSERT_SVH

// Clocked check, disabled while reset is asserted, with a fixed message.
`define SCLP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sclp: check failed");

// Clocked check, disabled while reset is asserted, with a caller message.
`define SCLP_ASSERT_MSG(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`endif

### design/sclp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclp_pkg
// Shared constants, codes and types of the serial command line parser.
// ----------------------------------------------------------------------------
package sclp_pkg;

  localparam int NumButtons   = 4;
  localparam int LineCapacity = 16;
  localparam int PotCount     = 2;
  localparam int PotMax       = 1023;
  localparam int MagSat       = 1024;

  localparam int PosW = $clog2(LineCapacity);
  localparam int MagW = 11;
  localparam int PotW = 10;
  localparam int IdxW = 8;

  // Characters
  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharHt     = 8'h09;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharCr     = 8'h0D;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharBang   = 8'h21;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharOne    = 8'h31;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharColon  = 8'h3A;
  localparam logic [7:0] CharUpperB = 8'h42;
  localparam logic [7:0] CharUpperP = 8'h50;

  // Command kinds
  localparam logic [1:0] KindNone   = 2'd0;
  localparam logic [1:0] KindButton = 2'd1;
  localparam logic [1:0] KindPot    = 2'd2;

  // Number parse phases
  localparam logic [1:0] PhSkip   = 2'd0;
  localparam logic [1:0] PhSign   = 2'd1;
  localparam logic [1:0] PhDigits = 2'd2;
  localparam logic [1:0] PhDone   = 2'd3;

  // Write request from the parser to the button and pot store
  typedef struct packed {
    logic            applied;
    logic            btn_we;
    logic            btn_val;
    logic            pot_we;
    logic [IdxW-1:0] index;
    logic [PotW-1:0] pot_val;
  } sclp_update_t;

endpackage

### design/serial_command_line_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_line_parser
// Parses "!Bn:v" and "!Pn:v" command lines from a serial byte stream.
// ----------------------------------------------------------------------------
// Every accepted byte yields exactly one result transaction carrying the
// button bitmap, both pot values and a flag set when that byte (a CR or LF)
// closed a line whose command was applied. A byte is held in an input
// register, parsed by one short combinational step, and moves into the
// result register once that register is free or being drained; one byte
// per cycle is sustained while the result side keeps taking transactions.
// The button and pot registers themselves form the result payload, so
// they change only when a new result is loaded.
// ----------------------------------------------------------------------------
`include "serial_command_line_parser_assert.svh"

module serial_command_line_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [3:0]                button_bits_o,
  output logic [sclp_pkg::PotW-1:0] pot_first_o,
  output logic [sclp_pkg::PotW-1:0] pot_second_o,
  output logic                      command_applied_o
);
  import sclp_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         out_valid_q;
  logic         applied_q;
  logic         load;
  sclp_update_t upd;

  // Advance the held byte whenever the result register is free or being
  // drained in this cycle.
  assign load       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || load;

  // Input register: hold the byte until it moves into the result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Line parse state and update decode
  sclp_line_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (load),
    .byte_i (in_byte_q),
    .upd_o  (upd)
  );

  // Button and pot state, doubling as the result payload
  sclp_store u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (load),
    .upd_i         (upd),
    .button_bits_o (button_bits_o),
    .pot_first_o   (pot_first_o),
    .pot_second_o  (pot_second_o)
  );

  // Result register: valid and the applied flag; drop valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      applied_q   <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      applied_q   <= upd.applied;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign command_applied_o = applied_q;

  `SCLP_ASSERT_MSG(a_stall_holds_state,
                   out_valid_o && !out_ready_i |=>
                     $stable(button_bits_o) && $stable(pot_first_o) &&
                     $stable(pot_second_o) && $stable(command_applied_o),
                   "sclp: result changed while stalled")
  `SCLP_ASSERT(a_ready_only_when_blocked,
               !in_ready_o |-> in_valid_q && out_valid_q && !out_ready_i)
  `SCLP_ASSERT(a_load_sets_valid, load |=> out_valid_q)

endmodule

### design/sclp_line_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclp_line_parser
// Per-line parse state; decodes one byte per enabled cycle and issues the
// store update when a CR or LF closes a well-formed command line.
// ----------------------------------------------------------------------------
`include "serial_command_line_parser_assert.svh"

module sclp_line_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [7:0]            byte_i,
  output sclp_pkg::sclp_update_t upd_o
);
  import sclp_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic            hdr_q, hdr_d;
  logic [1:0]      kind_q, kind_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [1:0]      phase_q, phase_d;
  logic            neg_q, neg_d;
  logic [MagW-1:0] mag_q, mag_d;

  logic            is_eol, is_digit, is_space, is_sign;
  logic [MagW+3:0] mag_next;

  assign is_eol   = (byte_i == CharLf) || (byte_i == CharCr);
  assign is_digit = byte_i inside {[CharZero:CharNine]};
  assign is_space = byte_i inside {CharSpace, [CharHt:CharCr]};
  assign is_sign  = (byte_i == CharPlus) || (byte_i == CharMinus);
  assign mag_next = (MagW+4)'(mag_q) * (MagW+4)'(10) + (MagW+4)'(byte_i - CharZero);

  always_comb begin
    pos_d   = pos_q;
    hdr_d   = hdr_q;
    kind_d  = kind_q;
    idx_d   = idx_q;
    phase_d = phase_q;
    neg_d   = neg_q;
    mag_d   = mag_q;
    upd_o   = '0;
    upd_o.index   = idx_q;
    upd_o.btn_val = (mag_q != '0);
    upd_o.pot_val = neg_q ? '0 :
                    (mag_q > MagW'(PotMax)) ? PotW'(PotMax) : mag_q[PotW-1:0];

    if (is_eol) begin
      if (pos_q != '0) begin
        if ((pos_q >= PosW'(4)) && hdr_q) begin
          if ((kind_q == KindButton) && (idx_q < IdxW'(NumButtons))) begin
            upd_o.applied = 1'b1;
            upd_o.btn_we  = 1'b1;
          end else if ((kind_q == KindPot) && (idx_q < IdxW'(PotCount))) begin
            upd_o.applied = 1'b1;
            upd_o.pot_we  = 1'b1;
          end
        end
        // clear the line
        pos_d   = '0;
        hdr_d   = 1'b0;
        kind_d  = KindNone;
        idx_d   = '0;
        phase_d = PhSkip;
        neg_d   = 1'b0;
        mag_d   = '0;
      end
    end else if (pos_q < PosW'(LineCapacity - 1)) begin
      case (pos_q)
        PosW'(0): hdr_d = (byte_i == CharBang);
        PosW'(1): kind_d = (byte_i == CharUpperB) ? KindButton :
                           (byte_i == CharUpperP) ? KindPot : KindNone;
        PosW'(2): idx_d = IdxW'(byte_i - CharOne);
        PosW'(3): hdr_d = hdr_q && (byte_i == CharColon);
        default: begin
          if (byte_i == CharNul) begin
            phase_d = PhDone;
          end else if (phase_q != PhDone) begin
            if (is_digit) begin
              mag_d   = (mag_next > (MagW+4)'(MagSat)) ? MagW'(MagSat)
                                                      : mag_next[MagW-1:0];
              phase_d = PhDigits;
            end else if ((phase_q == PhSkip) && is_space) begin
              phase_d = PhSkip;
            end else if ((phase_q == PhSkip) && is_sign) begin
              neg_d   = (byte_i == CharMinus);
              phase_d = PhSign;
            end else begin
              phase_d = PhDone;
            end
          end
        end
      endcase
      pos_d = pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      hdr_q   <= 1'b0;
      kind_q  <= KindNone;
      idx_q   <= '0;
      phase_q <= PhSkip;
      neg_q   <= 1'b0;
      mag_q   <= '0;
    end else if (en_i) begin
      pos_q   <= pos_d;
      hdr_q   <= hdr_d;
      kind_q  <= kind_d;
      idx_q   <= idx_d;
      phase_q <= phase_d;
      neg_q   <= neg_d;
      mag_q   <= mag_d;
    end
  end

  `SCLP_ASSERT(a_pos_bounded, pos_q <= PosW'(LineCapacity - 1))
  `SCLP_ASSERT_MSG(a_mag_saturates, mag_q <= MagW'(MagSat), "sclp: magnitude above limit")
  `SCLP_ASSERT_MSG(a_apply_on_eol, upd_o.applied |-> is_eol && (pos_q >= PosW'(4)),
                   "sclp: command applied without line end")

endmodule

### design/sclp_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclp_store
// Button and potentiometer state; takes one update per enabled cycle.
// ----------------------------------------------------------------------------
module sclp_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  sclp_pkg::sclp_update_t        upd_i,
  output logic [3:0]                    button_bits_o,
  output logic [sclp_pkg::PotW-1:0]     pot_first_o,
  output logic [sclp_pkg::PotW-1:0]     pot_second_o
);
  import sclp_pkg::*;

  logic [NumButtons-1:0] btn_q, btn_d;
  logic [PotW-1:0]       pot0_q, pot0_d;
  logic [PotW-1:0]       pot1_q, pot1_d;

  always_comb begin
    btn_d  = btn_q;
    pot0_d = pot0_q;
    pot1_d = pot1_q;
    for (int i = 0; i < NumButtons; i++) begin
      if (upd_i.btn_we && (upd_i.index == IdxW'(i))) begin
        btn_d[i] = upd_i.btn_val;
      end
    end
    if (upd_i.pot_we && (upd_i.index == IdxW'(0))) begin
      pot0_d = upd_i.pot_val;
    end
    if (upd_i.pot_we && (upd_i.index == IdxW'(1))) begin
      pot1_d = upd_i.pot_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_q  <= '0;
      pot0_q <= '0;
      pot1_q <= '0;
    end else if (en_i) begin
      btn_q  <= btn_d;
      pot0_q <= pot0_d;
      pot1_q <= pot1_d;
    end
  end

  // Only the first four buttons are visible; missing ones read as zero.
  for (genvar g = 0; g < 4; g++) begin : g_btn_out
    if (g < NumButtons) begin : g_live
      assign button_bits_o[g] = btn_q[g];
    end else begin : g_absent
      assign button_bits_o[g] = 1'b0;
    end
  end

  assign pot_first_o  = pot0_q;
  assign pot_second_o = pot1_q;

endmodule
